@@ hw/rtl/mssc_pkg.sv @@
// Package with shared types and constants of the symmetric sort matrix core.
package mssc_pkg;

	localparam int MaxSize = 16;
	localparam int IdxW = 4;
	localparam int AddrW = 8;
	localparam int ValW = 32;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SORT  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_WR,
		ST_SORT,
		ST_PERM_RD,
		ST_PERM_WR,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/matrix_symmetric_sort_by_column_core.sv @@
// Top level of the symmetric sort matrix core: entry store, stable sort and permutation.
//
// Usage: input items arrive on the s_axis channel (tvalid, tready, tdata). Each item is a
// write, a read, a sort request or a no-op. Results leave on the m_axis channel; tuser
// carries the result kind (0 read data, 1 sort finished). The cfg channel writes size_in_use.
// A write gives no result. A read result passes the registered read port of the matrix
// memory and then the output register; no new read is taken before it has left. A sort
// gathers the key column row by row, runs an insertion sort one compare step a cycle
// (skipped for a single row), then builds the permuted matrix in a scratch memory entry
// by entry and copies it back. A bad key column finishes at once, with no sort. Input is
// not accepted while an item is in progress or while a result waits in the output
// register; when the receiver stalls, the result holds.
// Reset clears the control state, sets size_in_use to 16 and the permutation to identity;
// the matrix contents are undefined until written.
module matrix_symmetric_sort_by_column_core
	import mssc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[1:0], row_index[5:2], col_index[9:6], entry_value[41:10],
	// key_column[45:42], descending[46], zero fill [47]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[31:0], bad_column[32], zero fill [39:33]
	output logic [39:0] m_axis_tdata,
	// result_kind[0]
	output logic        m_axis_tuser
);

	logic [4:0] size_q;
	logic [4:0] n;
	state_t state_q, state_d;

	// Input fields.
	logic [1:0]      in_op;
	logic [IdxW-1:0] in_row, in_col, in_key;
	logic [ValW-1:0] in_val;
	logic            in_desc;
	assign in_op   = s_axis_tdata[1:0];
	assign in_row  = s_axis_tdata[5:2];
	assign in_col  = s_axis_tdata[9:6];
	assign in_val  = s_axis_tdata[41:10];
	assign in_key  = s_axis_tdata[45:42];
	assign in_desc = s_axis_tdata[46];

	// Memories.
	logic [ValW-1:0] mat_mem [MaxSize*MaxSize];
	logic [ValW-1:0] scr_mem [MaxSize*MaxSize];
	logic [ValW-1:0] key_mem [MaxSize];
	logic [IdxW-1:0] ord_q [MaxSize];

	logic [AddrW-1:0] mat_raddr, mat_waddr, scr_raddr;
	logic             mat_we, scr_we;
	logic [ValW-1:0]  mat_wdata, mat_rdata_q, scr_rdata_q;

	// Sequencer registers.
	logic [IdxW-1:0] key_col_q;
	logic            desc_q;
	logic [4:0]      ci_q, ck_q;   // outer loop counters, wide enough to hold n
	logic [4:0]      sj_q;         // insertion position
	logic [IdxW-1:0] cur_q;        // index being inserted
	logic            read_pend_q;
	logic            rd_in_range_q;
	logic            out_valid_q;
	logic            out_kind_q;
	logic            out_bad_q;
	logic [ValW-1:0] out_val_q;

	logic accept_in;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q && !read_pend_q;
	assign accept_in = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Effective size, clamped to one through MaxSize.
	always_comb begin
		if (size_q == 5'd0) n = 5'd1;
		else if (size_q > 5'(MaxSize)) n = 5'(MaxSize);
		else n = size_q;
	end

	logic in_range;
	assign in_range = ({1'b0, in_row} < n) && ({1'b0, in_col} < n);

	// Compare of the current key against the key one place lower.
	logic [IdxW-1:0] prev_idx;
	logic signed [ValW-1:0] ka, kb;
	logic            moves;
	assign prev_idx = ord_q[sj_q[IdxW-1:0] - 1'b1];
	assign ka = key_mem[cur_q];
	assign kb = key_mem[prev_idx];
	assign moves = (sj_q != 5'd0) && (desc_q ? (ka > kb) : (ka < kb));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in && op_t'(in_op) == OP_SORT && ({1'b0, in_key} < n))
					state_d = ST_KEY_RD;
			end
			ST_KEY_RD: state_d = ST_KEY_WR;
			ST_KEY_WR: begin
				if (ci_q + 5'd1 >= n) state_d = (n == 5'd1) ? ST_PERM_RD : ST_SORT;
				else state_d = ST_KEY_RD;
			end
			ST_SORT: begin
				if (!moves && (ci_q + 5'd1 >= n)) state_d = ST_PERM_RD;
			end
			ST_PERM_RD: state_d = ST_PERM_WR;
			ST_PERM_WR: begin
				if (ck_q + 5'd1 >= n && ci_q + 5'd1 >= n) state_d = ST_COPY_RD;
				else state_d = ST_PERM_RD;
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: begin
				if (ck_q + 5'd1 >= n && ci_q + 5'd1 >= n) state_d = ST_DONE;
				else state_d = ST_COPY_RD;
			end
			ST_DONE: state_d = out_valid_q ? ST_DONE : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory addressing per state.
	always_comb begin
		mat_raddr = {in_row, in_col};
		mat_waddr = {in_row, in_col};
		mat_wdata = in_val;
		mat_we    = 1'b0;
		scr_raddr = {ci_q[IdxW-1:0], ck_q[IdxW-1:0]};
		scr_we    = 1'b0;
		case (state_q)
			ST_IDLE: mat_we = accept_in && op_t'(in_op) == OP_WRITE && in_range;
			ST_KEY_RD: mat_raddr = {ci_q[IdxW-1:0], key_col_q};
			ST_PERM_RD: mat_raddr = {ord_q[ci_q[IdxW-1:0]], ord_q[ck_q[IdxW-1:0]]};
			ST_PERM_WR: scr_we = 1'b1;
			ST_COPY_WR: begin
				mat_we    = 1'b1;
				mat_waddr = {ci_q[IdxW-1:0], ck_q[IdxW-1:0]};
				mat_wdata = scr_rdata_q;
			end
			default: ;
		endcase
	end

	// Matrix memories with registered reads.
	always_ff @(posedge clk) begin
		if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
		mat_rdata_q <= mat_mem[mat_raddr];
		if (scr_we) scr_mem[{ci_q[IdxW-1:0], ck_q[IdxW-1:0]}] <= mat_rdata_q;
		scr_rdata_q <= scr_mem[scr_raddr];
		if (state_q == ST_KEY_WR) key_mem[ci_q[IdxW-1:0]] <= mat_rdata_q;
	end

	// Control, counters, permutation and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			size_q        <= 5'd16;
			ci_q          <= '0;
			ck_q          <= '0;
			sj_q          <= '0;
			cur_q         <= '0;
			key_col_q     <= '0;
			desc_q        <= 1'b0;
			read_pend_q   <= 1'b0;
			rd_in_range_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= 1'b0;
			out_bad_q     <= 1'b0;
			out_val_q     <= '0;
			for (int i = 0; i < MaxSize; i++) ord_q[i] <= IdxW'(i);
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) size_q <= cfg_data;
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			read_pend_q <= 1'b0;
			if (read_pend_q) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= 1'b0;
				out_bad_q   <= 1'b0;
				out_val_q   <= rd_in_range_q ? mat_rdata_q : '0;
			end
			case (state_q)
				ST_IDLE: begin
					ci_q <= '0;
					ck_q <= '0;
					if (accept_in) begin
						case (op_t'(in_op))
							OP_READ: begin
								read_pend_q   <= 1'b1;
								rd_in_range_q <= in_range;
							end
							OP_SORT: begin
								key_col_q <= in_key;
								desc_q    <= in_desc;
								if ({1'b0, in_key} >= n) begin
									out_valid_q <= 1'b1;
									out_kind_q  <= 1'b1;
									out_bad_q   <= 1'b1;
									out_val_q   <= '0;
								end else begin
									for (int i = 0; i < MaxSize; i++) ord_q[i] <= IdxW'(i);
								end
							end
							default: ;
						endcase
					end
				end
				ST_KEY_WR: begin
					if (ci_q + 5'd1 >= n) begin
						ci_q  <= (n == 5'd1) ? 5'd0 : 5'd1;
						sj_q  <= 5'd1;
						cur_q <= IdxW'(1);
					end else begin
						ci_q <= ci_q + 5'd1;
					end
				end
				ST_SORT: begin
					if (moves) begin
						ord_q[sj_q[IdxW-1:0]] <= prev_idx;
						sj_q <= sj_q - 5'd1;
					end else begin
						ord_q[sj_q[IdxW-1:0]] <= cur_q;
						if (ci_q + 5'd1 >= n) begin
							ci_q <= '0;
						end else begin
							ci_q  <= ci_q + 5'd1;
							sj_q  <= ci_q + 5'd1;
							cur_q <= ord_q[ci_q[IdxW-1:0] + 1'b1];
						end
					end
				end
				ST_PERM_WR, ST_COPY_WR: begin
					if (ck_q + 5'd1 >= n) begin
						ck_q <= '0;
						ci_q <= (ci_q + 5'd1 >= n) ? 5'd0 : ci_q + 5'd1;
					end else begin
						ck_q <= ck_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= 1'b1;
						out_bad_q   <= 1'b0;
						out_val_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output channel.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_bad_q, out_val_q};
	assign m_axis_tuser  = out_kind_q;

endmodule

@@ bench/matrix_symmetric_sort_by_column_core_tb.sv @@
// Self-checking testbench of the symmetric sort matrix core.
module matrix_symmetric_sort_by_column_core_tb;
	import mssc_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int SettleCycles = 24;
	localparam int RandomPhases = 6;
	localparam int PhaseItems = 55;
	localparam int LongHold = 600;

	typedef struct packed {
		op_t             op;
		logic [IdxW-1:0] row;
		logic [IdxW-1:0] col;
		logic [ValW-1:0] value;
		logic [IdxW-1:0] key;
		logic            desc;
	} host_item_t;

	typedef struct packed {
		logic            kind;
		logic [ValW-1:0] value;
		logic            bad;
	} result_t;

	// One row of the directed table; cfg_row rows write size_in_use instead.
	typedef struct {
		bit         cfg_row;
		logic [4:0] cfg_size;
		host_item_t item;
		bit         typed;
		result_t    typed_res;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [4:0]        cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [39:0]       m_axis_tdata;
	logic              m_axis_tuser;

	// Predictor state.
	logic signed [ValW-1:0] mat_model [MaxSize][MaxSize];
	logic [4:0]             size_reg;
	result_t                pending_results [$];

	int  mismatches = 0;
	int  cycles = 0;
	int  burst_left = 0;
	bit  hold_req = 0;
	directed_row_t directed_rows [$];

	matrix_symmetric_sort_by_column_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int eff_size();
		if (size_reg == 0) return 1;
		if (size_reg > MaxSize) return MaxSize;
		return int'(size_reg);
	endfunction

	// Applies one accepted item to the model and returns its result, if any.
	task automatic predict_item(input host_item_t it, output bit has, output result_t res);
		int n;
		int ord [MaxSize];
		logic signed [ValW-1:0] keys [MaxSize];
		logic signed [ValW-1:0] scratch [MaxSize][MaxSize];
		int cur, j;
		bit moves;
		n = eff_size();
		has = 0;
		res = '0;
		case (it.op)
			OP_WRITE: begin
				if (it.row < n && it.col < n) mat_model[it.row][it.col] = it.value;
			end
			OP_READ: begin
				has = 1;
				if (it.row < n && it.col < n) res.value = mat_model[it.row][it.col];
			end
			OP_SORT: begin
				has = 1;
				res.kind = 1'b1;
				if (it.key >= n) begin
					res.bad = 1'b1;
				end else begin
					for (int i = 0; i < n; i++) begin
						keys[i] = mat_model[i][it.key];
						ord[i] = i;
					end
					// Stable insertion sort: only strictly ordered keys move past.
					for (int i = 1; i < n; i++) begin
						cur = ord[i];
						j = i;
						moves = 1;
						while (j > 0 && moves) begin
							moves = it.desc ? (keys[cur] > keys[ord[j-1]])
								: (keys[cur] < keys[ord[j-1]]);
							if (moves) begin
								ord[j] = ord[j-1];
								j--;
							end
						end
						ord[j] = cur;
					end
					for (int i = 0; i < n; i++)
						for (int k = 0; k < n; k++)
							scratch[i][k] = mat_model[ord[i]][ord[k]];
					for (int i = 0; i < n; i++)
						for (int k = 0; k < n; k++)
							mat_model[i][k] = scratch[i][k];
				end
			end
			default: ;
		endcase
	endtask

	// Offers one item in bursts with random gaps and predicts it on transfer.
	task automatic send_item(input host_item_t it, input bit typed, input result_t typed_res);
		int gap;
		bit has;
		result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, it.desc, it.key, it.value, it.col, it.row, it.op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_item(it, has, res);
		if (has) pending_results.push_back(typed ? typed_res : res);
	endtask

	// Writes size_in_use once the block has drained.
	task automatic write_size(input logic [4:0] sz);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= sz;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		size_reg = sz;
	endtask

	function automatic logic [ValW-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(ValW-1){1'b1}}};
			1: return {1'b1, {(ValW-1){1'b0}}};
			2, 3: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic host_item_t rand_item();
		host_item_t it;
		int pick;
		int n;
		n = eff_size();
		pick = $urandom_range(0, 99);
		it.op = (pick < 45) ? OP_WRITE : (pick < 85) ? OP_READ : (pick < 95) ? OP_SORT : OP_NONE;
		it.row = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
		it.col = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
		it.value = rand_value();
		it.key = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
		it.desc = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic host_item_t mk(op_t op, int r, int c, logic [ValW-1:0] v, int k, bit d);
		host_item_t it;
		it.op = op;
		it.row = IdxW'(r);
		it.col = IdxW'(c);
		it.value = v;
		it.key = IdxW'(k);
		it.desc = d;
		return it;
	endfunction

	function automatic void add_row(host_item_t it, bit typed = 0, result_t tr = '0);
		directed_row_t row;
		row.cfg_row = 0;
		row.cfg_size = '0;
		row.item = it;
		row.typed = typed;
		row.typed_res = tr;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [4:0] sz);
		directed_row_t row;
		row.cfg_row = 1;
		row.cfg_size = sz;
		row.item = '0;
		row.typed = 0;
		row.typed_res = '0;
		directed_rows.push_back(row);
	endfunction

	// Receiver: the stall pattern is picked at random from three modes; a long hold-off on request.
	int rx_count = 0;
	int rx_mode = 0;
	int hold_count = 0;
	always @(posedge clk) begin
		rx_count <= rx_count + 1;
		if (rx_count % 64 == 0) rx_mode <= $urandom_range(0, 2);
		if (hold_req && hold_count < LongHold) begin
			hold_count <= hold_count + 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_req <= 0;
				hold_count <= 0;
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result checker: each transfer against the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.value = m_axis_tdata[31:0];
			got.bad = m_axis_tdata[32];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d value=%h bad=%0d",
						got.kind, got.value, got.bad);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind=%0d value=%h bad=%0d, got kind=%0d value=%h bad=%0d",
							want.kind, want.value, want.bad, got.kind, got.value, got.bad);
				end
			end
		end
	end

	initial begin
		result_t tr;
		size_reg = 5'd16;
		for (int i = 0; i < MaxSize; i++)
			for (int k = 0; k < MaxSize; k++)
				mat_model[i][k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every entry so that no read or sort ever touches an unwritten one.
		for (int i = 0; i < MaxSize; i++)
			for (int k = 0; k < MaxSize; k++)
				send_item(mk(OP_WRITE, i, k, rand_value(), 0, 0), 0, '0);

		// Directed table: extremes, every operation and the special cases.
		tr = '0;
		tr.value = 32'h7FFF_FFFF;
		add_row(mk(OP_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 0));
		add_row(mk(OP_READ, 0, 0, 0, 0, 0), 1, tr);
		tr.value = 32'h8000_0000;
		add_row(mk(OP_WRITE, 15, 15, 32'h8000_0000, 0, 0));
		add_row(mk(OP_READ, 15, 15, 0, 0, 0), 1, tr);
		add_row(mk(OP_SORT, 0, 0, 0, 0, 0));
		add_row(mk(OP_READ, 0, 0, 0, 0, 0));
		add_row(mk(OP_SORT, 0, 0, 0, 15, 1));
		add_row(mk(OP_READ, 15, 0, 0, 0, 0));
		add_row(mk(OP_NONE, 3, 3, 32'hFFFF_FFFF, 15, 1));
		add_cfg(5'd4);
		tr = '0;
		tr.kind = 1'b1;
		tr.bad = 1'b1;
		add_row(mk(OP_SORT, 0, 0, 0, 4, 0), 1, tr);
		add_row(mk(OP_SORT, 0, 0, 0, 15, 1), 1, tr);
		tr = '0;
		add_row(mk(OP_READ, 5, 5, 0, 0, 0), 1, tr);
		add_row(mk(OP_WRITE, 6, 1, 32'h1234_5678, 0, 0));
		add_row(mk(OP_WRITE, 1, 3, 32'd0, 0, 0));
		add_row(mk(OP_WRITE, 2, 3, 32'd0, 0, 0));
		add_row(mk(OP_SORT, 0, 0, 0, 3, 0));
		add_row(mk(OP_READ, 3, 3, 0, 0, 0));
		add_cfg(5'd0);
		add_row(mk(OP_SORT, 0, 0, 0, 0, 1));
		add_row(mk(OP_READ, 0, 1, 0, 0, 0));
		add_cfg(5'd31);
		add_row(mk(OP_READ, 15, 14, 0, 0, 0));
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg_row) write_size(directed_rows[i].cfg_size);
			else send_item(directed_rows[i].item, directed_rows[i].typed,
				directed_rows[i].typed_res);
		end

		// Random phases, each at its own size; the third starts with a long receiver hold.
		for (int p = 0; p < RandomPhases; p++) begin
			case (p)
				0: write_size(5'd3);
				1: write_size(5'd1);
				2: write_size(5'd6);
				3: write_size(5'd16);
				4: write_size(5'd2);
				default: write_size(5'($urandom_range(0, 31)));
			endcase
			if (p == 2) hold_req = 1;
			for (int i = 0; i < PhaseItems; i++) begin
				if (eff_size() == MaxSize && $urandom_range(0, 1) == 0) begin
					host_item_t it;
					it = rand_item();
					if (it.op == OP_SORT) it.op = OP_READ;
					send_item(it, 0, '0);
				end else begin
					send_item(rand_item(), 0, '0);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mssc_pkg.sv
hw/rtl/matrix_symmetric_sort_by_column_core.sv
bench/matrix_symmetric_sort_by_column_core_tb.sv
